// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define CLPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that stays active through reset
`define CLPT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/clpt_pkg.sv
// ----------------------------------------------------------------------------
// clpt_pkg
// Shared types, codes and defaults of the command line pipe tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package clpt_pkg;

  // Default limits
  localparam int LINE_MAX_LEN_DEF = 4096;
  localparam int MAX_ARGS_DEF     = 64;
  localparam int MAX_STAGES_DEF   = 64;

  // Input kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Special bytes
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // Result event codes
  typedef enum logic [1:0] {
    EV_WORD = 2'd0,
    EV_PIPE = 2'd1,
    EV_END  = 2'd2
  } event_t;

  // Lexer state, one-hot
  typedef enum logic [3:0] {
    ST_BLANK = 4'b0001,
    ST_WORD  = 4'b0010,
    ST_SQ    = 4'b0100,
    ST_DQ    = 4'b1000
  } lex_state_t;

  // Lexer to result queue: number of results pushed this cycle (0..2)
  typedef struct packed {
    logic [1:0] count;
  } push_t;

  // Result queue status back to the lexer
  typedef struct packed {
    logic room;  // at least two free entries
  } q_stat_t;

  // Tab, newline, vertical tab, form feed, carriage return, space
  function automatic logic is_blank(logic [7:0] c);
    return (c inside {8'd32, [8'd9:8'd13]});
  endfunction

endpackage

`default_nettype wire

// File: design/clpt_lexer.sv
// ----------------------------------------------------------------------------
// clpt_lexer
// Input register, lexer state and per-byte result generation (0..2 results).
// ----------------------------------------------------------------------------
`default_nettype none

module clpt_lexer import clpt_pkg::*; #(
  parameter int LINE_MAX_LEN = LINE_MAX_LEN_DEF,
  parameter int MAX_ARGS     = MAX_ARGS_DEF,
  parameter int MAX_STAGES   = MAX_STAGES_DEF,
  parameter int QW           = 43
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output      logic          s_tready,
  input  wire logic [7:0]    s_tdata,   // [7:0] char_code
  input  wire logic          s_tuser,   // [0] kind
  input  wire q_stat_t       q_stat,
  output      push_t         push,
  output      logic [QW-1:0] res0,
  output      logic [QW-1:0] res1
);

  localparam int START_W = $clog2(LINE_MAX_LEN);
  localparam int LEN_W   = $clog2(LINE_MAX_LEN + 1);
  localparam int ARG_W   = $clog2(MAX_ARGS + 1);
  localparam int STG_W   = $clog2(MAX_STAGES);
  localparam int FLD_W   = START_W + LEN_W + ARG_W + STG_W + 1;
  localparam int TDATA_W = ((FLD_W + 7) / 8) * 8;

  // Pack one result: {tlast, tuser, tdata}
  function automatic logic [QW-1:0] pack_res(event_t ev, logic [START_W-1:0] st,
                                             logic [LEN_W-1:0] ln, logic [ARG_W-1:0] ai,
                                             logic [STG_W-1:0] si, logic ov, logic lst);
    logic [TDATA_W-1:0] d;
    d = '0;
    d[FLD_W-1:0] = {ov, si, ai, ln, st};
    return {lst, ev, d};
  endfunction

  // Input register
  logic       in_vld;
  logic       in_kind;
  logic [7:0] in_char;
  logic       adv;

  // Lexer state
  lex_state_t         st, st_next;
  logic [LEN_W-1:0]   pos, pos_next;
  logic [START_W-1:0] start, start_next;
  logic [ARG_W-1:0]   argc, argc_next;
  logic [STG_W-1:0]   stg, stg_next;
  logic               ovf, ovf_next;

  assign adv      = in_vld & q_stat.room;
  assign s_tready = ~in_vld | q_stat.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_char <= s_tdata;
    end
  end

  // Shared terms
  logic               pos_sat, q_clamp, blank, argc_full, stg_full;
  logic               ovf_c, ovf_w;
  logic [LEN_W-1:0]   word_len;
  logic [LEN_W:0]     pos_p1;
  logic [START_W-1:0] start_cur, start_q;
  logic [ARG_W-1:0]   argc_inc;
  logic [STG_W-1:0]   stg_inc;

  always_comb begin
    pos_sat   = (pos == LEN_W'(LINE_MAX_LEN));
    pos_p1    = {1'b0, pos} + 1'b1;
    q_clamp   = (pos >= LEN_W'(LINE_MAX_LEN - 1));
    start_cur = pos_sat ? START_W'(LINE_MAX_LEN - 1) : pos[START_W-1:0];
    start_q   = q_clamp ? START_W'(LINE_MAX_LEN - 1) : pos_p1[START_W-1:0];
    blank     = is_blank(in_char);
    argc_full = (argc == ARG_W'(MAX_ARGS));
    argc_inc  = argc_full ? argc : argc + 1'b1;
    stg_full  = (stg == STG_W'(MAX_STAGES - 1));
    stg_inc   = stg_full ? stg : stg + 1'b1;
    // word ends at the current position both for a byte and for end of line
    word_len  = (pos > LEN_W'(start)) ? pos - LEN_W'(start) : '0;
    ovf_c     = ovf | pos_sat;
    ovf_w     = ovf_c | argc_full;
  end

  // Next state and results
  always_comb begin
    st_next    = st;
    pos_next   = pos;
    start_next = start;
    argc_next  = argc;
    stg_next   = stg;
    ovf_next   = ovf;
    push.count = 2'd0;
    res0       = '0;
    res1       = '0;
    if (in_kind == KIND_EOL) begin
      // end of line: flush word, close final stage, back to reset values
      if (st != ST_BLANK) begin
        push.count = 2'd2;
        res0 = pack_res(EV_WORD, start, word_len, argc, stg, ovf | argc_full, 1'b0);
        res1 = pack_res(EV_END, '0, '0, argc_inc, stg, ovf | argc_full, 1'b1);
      end else begin
        push.count = 2'd1;
        res0 = pack_res(EV_END, '0, '0, argc, stg, ovf, 1'b1);
      end
      st_next    = ST_BLANK;
      pos_next   = '0;
      start_next = '0;
      argc_next  = '0;
      stg_next   = '0;
      ovf_next   = 1'b0;
    end else begin
      pos_next = pos_sat ? pos : pos_p1[LEN_W-1:0];
      ovf_next = ovf_c;
      case (st)
        ST_BLANK: begin
          if (blank) begin
            st_next = ST_BLANK;
          end else if (in_char == CH_SQUOTE || in_char == CH_DQUOTE) begin
            start_next = start_q;
            ovf_next   = ovf_c | q_clamp;
            st_next    = (in_char == CH_DQUOTE) ? ST_DQ : ST_SQ;
          end else if (in_char == CH_PIPE) begin
            push.count = 2'd1;
            res0       = pack_res(EV_PIPE, '0, '0, argc, stg, ovf_c | stg_full, 1'b1);
            stg_next   = stg_inc;
            argc_next  = '0;
            ovf_next   = ovf_c | stg_full;
          end else begin
            start_next = start_cur;
            st_next    = ST_WORD;
          end
        end
        ST_WORD: begin
          if (blank) begin
            push.count = 2'd1;
            res0       = pack_res(EV_WORD, start, word_len, argc, stg, ovf_w, 1'b1);
            argc_next  = argc_inc;
            ovf_next   = ovf_w;
            st_next    = ST_BLANK;
          end else if (in_char == CH_PIPE) begin
            push.count = 2'd2;
            res0       = pack_res(EV_WORD, start, word_len, argc, stg, ovf_w, 1'b0);
            res1       = pack_res(EV_PIPE, '0, '0, argc_inc, stg, ovf_w | stg_full, 1'b1);
            argc_next  = '0;
            stg_next   = stg_inc;
            ovf_next   = ovf_w | stg_full;
            st_next    = ST_BLANK;
          end
        end
        ST_SQ: begin
          if (in_char == CH_SQUOTE) begin
            push.count = 2'd1;
            res0       = pack_res(EV_WORD, start, word_len, argc, stg, ovf_w, 1'b1);
            argc_next  = argc_inc;
            ovf_next   = ovf_w;
            st_next    = ST_BLANK;
          end
        end
        ST_DQ: begin
          if (in_char == CH_DQUOTE) begin
            push.count = 2'd1;
            res0       = pack_res(EV_WORD, start, word_len, argc, stg, ovf_w, 1'b1);
            argc_next  = argc_inc;
            ovf_next   = ovf_w;
            st_next    = ST_BLANK;
          end
        end
        default: begin
          st_next = ST_BLANK;
        end
      endcase
    end
    if (!adv) begin
      push.count = 2'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_BLANK;
      pos   <= '0;
      start <= '0;
      argc  <= '0;
      stg   <= '0;
      ovf   <= 1'b0;
    end else if (adv) begin
      st    <= st_next;
      pos   <= pos_next;
      start <= start_next;
      argc  <= argc_next;
      stg   <= stg_next;
      ovf   <= ovf_next;
    end
  end

endmodule

`default_nettype wire

// File: design/clpt_res_queue.sv
// ----------------------------------------------------------------------------
// clpt_res_queue
// Four-entry result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clpt_res_queue import clpt_pkg::*; #(
  parameter int DW = 43
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire push_t         push,
  input  wire logic [DW-1:0] din0,
  input  wire logic [DW-1:0] din1,
  output      q_stat_t       q_stat,
  output      logic          dvalid,
  input  wire logic          dready,
  output      logic [DW-1:0] dout
);

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  logic [DW-1:0]    mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign wr_ptr1     = wr_ptr + 1'b1;
  assign pop         = dvalid & dready;
  assign dvalid      = (count != '0);
  assign dout        = mem[rd_ptr];
  assign q_stat.room = (count <= CNT_W'(QDEPTH - 2));

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= din0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= din1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// File: design/command_line_pipe_tokenizer_core.sv
// ----------------------------------------------------------------------------
// command_line_pipe_tokenizer_core
// Shell-style word and pipe-stage tokenizer for a byte stream.
// ----------------------------------------------------------------------------
// Takes one command line byte per cycle (s_tuser = 0) and an end-of-line
// transaction (s_tuser = 1) after the last byte. Every byte or end of line
// yields zero, one or two result transactions: a word (start, length, index
// in stage), a stage closed by a pipe, or the final stage at end of line;
// m_tlast marks the last result of an input transaction. An input is
// registered, decoded from the input register and its results are written
// to a four-entry queue that drives the output. The input accepts one
// transaction per cycle while the queue has two free entries; the output
// delivers one result per cycle while m_tready is high, so sustained input
// rate is one byte per cycle as long as results average at most one per
// input (a word closed by a pipe or by end of line yields two results).
`default_nettype none

module command_line_pipe_tokenizer_core import clpt_pkg::*; #(
  parameter int LINE_MAX_LEN = LINE_MAX_LEN_DEF,
  parameter int MAX_ARGS     = MAX_ARGS_DEF,
  parameter int MAX_STAGES   = MAX_STAGES_DEF,
  localparam int START_W     = $clog2(LINE_MAX_LEN),
  localparam int LEN_W       = $clog2(LINE_MAX_LEN + 1),
  localparam int ARG_W       = $clog2(MAX_ARGS + 1),
  localparam int STG_W       = $clog2(MAX_STAGES),
  localparam int FLD_W       = START_W + LEN_W + ARG_W + STG_W + 1,
  localparam int TDATA_W     = ((FLD_W + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire logic [7:0]         s_tdata,   // char_code
  input  wire logic               s_tuser,   // kind
  output      logic               m_tvalid,
  input  wire logic               m_tready,
  // token_start, token_length, arg_index, stage_index, overflow, zero fill
  output      logic [TDATA_W-1:0] m_tdata,
  output      logic [1:0]         m_tuser,   // event_res
  output      logic               m_tlast    // last
);

  localparam int QW = TDATA_W + 3;

  push_t         push;
  q_stat_t       q_stat;
  logic [QW-1:0] res0, res1, head;

  // Byte decode and lexer state
  clpt_lexer #(
    .LINE_MAX_LEN (LINE_MAX_LEN),
    .MAX_ARGS     (MAX_ARGS),
    .MAX_STAGES   (MAX_STAGES),
    .QW           (QW)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  // Result queue
  clpt_res_queue #(
    .DW (QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din0   (res0),
    .din1   (res1),
    .q_stat (q_stat),
    .dvalid (m_tvalid),
    .dready (m_tready),
    .dout   (head)
  );

  // Output split
  assign m_tdata = head[TDATA_W-1:0];
  assign m_tuser = head[TDATA_W +: 2];
  assign m_tlast = head[TDATA_W + 2];

endmodule

`default_nettype wire

// File: design/clpt_checker.sv
// ----------------------------------------------------------------------------
// clpt_checker
// Port-level assertions for the command line pipe tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clpt_checker import clpt_pkg::*; #(
  parameter int LINE_MAX_LEN = LINE_MAX_LEN_DEF,
  parameter int MAX_ARGS     = MAX_ARGS_DEF,
  parameter int MAX_STAGES   = MAX_STAGES_DEF,
  localparam int START_W     = $clog2(LINE_MAX_LEN),
  localparam int LEN_W       = $clog2(LINE_MAX_LEN + 1),
  localparam int ARG_W       = $clog2(MAX_ARGS + 1),
  localparam int STG_W       = $clog2(MAX_STAGES),
  localparam int FLD_W       = START_W + LEN_W + ARG_W + STG_W + 1,
  localparam int TDATA_W     = ((FLD_W + 7) / 8) * 8
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic [1:0]         m_tuser,
  input wire logic               m_tlast
);

  // Output transaction holds while stalled
  `CLPT_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
  `CLPT_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser),
               "output payload changed while stalled")

  // End of line closes the item's results
  `CLPT_ASSERT(a_end_last, m_tvalid && m_tuser == EV_END |-> m_tlast,
               "final stage event not marked last")

  // Stage events carry no word position
  `CLPT_ASSERT(a_stage_zero,
               m_tvalid && m_tuser != EV_WORD |-> m_tdata[START_W+LEN_W-1:0] == '0,
               "stage event with nonzero start or length")

  // Queue is empty after reset
  `CLPT_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind command_line_pipe_tokenizer_core clpt_checker #(
  .LINE_MAX_LEN (LINE_MAX_LEN),
  .MAX_ARGS     (MAX_ARGS),
  .MAX_STAGES   (MAX_STAGES)
) u_clpt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: dv/token_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_stream_checker
// Predicts and checks the word and stage results of the line tokenizer.
// ----------------------------------------------------------------------------
// Watches both stream channels of the tokenizer. Every accepted input
// transaction is run through a local model of the lexer, and the words and
// stage events it causes are queued in order. Every accepted result
// transaction is compared field by field with the oldest queued one.
// Mismatches and results with nothing queued are counted and reported.

module token_stream_checker import clpt_pkg::*; #(
  parameter int TDATA_W = 40
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  input  wire logic               s_tready,
  input  wire logic [7:0]         s_tdata,   // char_code
  input  wire logic               s_tuser,   // kind
  input  wire logic               m_tvalid,
  input  wire logic               m_tready,
  // token_start, token_length, arg_index, stage_index, overflow, zero fill
  input  wire logic [TDATA_W-1:0] m_tdata,
  input  wire logic [1:0]         m_tuser,   // event_res
  input  wire logic               m_tlast,   // last
  output int                      mismatches,
  output int                      outstanding,
  output int                      results_seen,
  output int                      overflow_seen
);

  localparam int LINE_MAX   = LINE_MAX_LEN_DEF;
  localparam int ARGS_MAX   = MAX_ARGS_DEF;
  localparam int STAGES_MAX = MAX_STAGES_DEF;
  localparam int START_W    = $clog2(LINE_MAX);
  localparam int LEN_W      = $clog2(LINE_MAX + 1);
  localparam int ARG_W      = $clog2(ARGS_MAX + 1);
  localparam int STG_W      = $clog2(STAGES_MAX);
  localparam int FLD_W      = START_W + LEN_W + ARG_W + STG_W + 1;

  typedef struct packed {
    event_t             ev;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [ARG_W-1:0]   arg;
    logic [STG_W-1:0]   stg;
    logic               ovf;
    logic               last;
  } token_result_t;

  // Expected results, oldest first
  token_result_t token_q[$];

  // Results of the transaction being predicted (at most two)
  token_result_t burst[2];
  int            burst_n;

  // Lexer state of the prediction
  lex_state_t lex;
  int         line_pos;
  int         tok_start;
  int         arg_cnt;
  int         stage_cnt;
  logic       ovf_flag;

  task clear_line();
    lex       = ST_BLANK;
    line_pos  = 0;
    tok_start = 0;
    arg_cnt   = 0;
    stage_cnt = 0;
    ovf_flag  = 1'b0;
  endtask

  task add_result(event_t ev, int st, int ln, int ai, int si);
    token_result_t r;
    r.ev    = ev;
    r.start = st[START_W-1:0];
    r.len   = ln[LEN_W-1:0];
    r.arg   = ai[ARG_W-1:0];
    r.stg   = si[STG_W-1:0];
    r.ovf   = ovf_flag;
    r.last  = 1'b0;
    burst[burst_n] = r;
    burst_n++;
  endtask

  // Word ends at end_p; the index saturates at the argument limit
  task close_word(int end_p);
    int ln;
    int idx;
    ln  = (end_p > tok_start) ? end_p - tok_start : 0;
    idx = arg_cnt;
    if (arg_cnt < ARGS_MAX) arg_cnt++;
    else ovf_flag = 1'b1;
    add_result(EV_WORD, tok_start, ln, idx, stage_cnt);
  endtask

  // Stage event; a pipe moves on to the next stage, saturating at the limit
  task close_stage(event_t ev);
    int stg;
    int cnt;
    stg = stage_cnt;
    cnt = arg_cnt;
    if (ev == EV_PIPE) begin
      if (stage_cnt + 1 < STAGES_MAX) stage_cnt++;
      else ovf_flag = 1'b1;
      arg_cnt = 0;
    end
    add_result(ev, 0, 0, cnt, stg);
  endtask

  // Word start clamps to the last position of the line
  task mark_start(int p);
    if (p > LINE_MAX - 1) begin
      p        = LINE_MAX - 1;
      ovf_flag = 1'b1;
    end
    tok_start = p;
  endtask

  // Predict the results of one input transaction and queue them
  task tokenize(logic kind, logic [7:0] c);
    int            cur;
    logic          blank;
    token_result_t r;
    burst_n = 0;
    if (kind == KIND_EOL) begin
      if (lex != ST_BLANK) close_word(line_pos);
      close_stage(EV_END);
      clear_line();
    end else begin
      if (line_pos < LINE_MAX) begin
        cur = line_pos;
        line_pos++;
      end else begin
        cur      = LINE_MAX;
        ovf_flag = 1'b1;
      end
      blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
      case (lex)
        ST_BLANK: begin
          if (blank) begin
          end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            mark_start(cur + 1);
            lex = (c == CH_DQUOTE) ? ST_DQ : ST_SQ;
          end else if (c == CH_PIPE) begin
            close_stage(EV_PIPE);
          end else begin
            mark_start(cur);
            lex = ST_WORD;
          end
        end
        ST_WORD: begin
          if (blank) begin
            close_word(cur);
            lex = ST_BLANK;
          end else if (c == CH_PIPE) begin
            close_word(cur);
            close_stage(EV_PIPE);
            lex = ST_BLANK;
          end
        end
        ST_SQ: begin
          if (c == CH_SQUOTE) begin
            close_word(cur);
            lex = ST_BLANK;
          end
        end
        default: begin
          if (c == CH_DQUOTE) begin
            close_word(cur);
            lex = ST_BLANK;
          end
        end
      endcase
    end
    if (burst_n > 0) begin
      r                  = burst[burst_n-1];
      r.last             = 1'b1;
      burst[burst_n-1]   = r;
    end
    for (int i = 0; i < burst_n; i++) token_q.push_back(burst[i]);
  endtask

  task check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare one accepted result transaction with the oldest expectation
  task check_result();
    token_result_t e;
    results_seen++;
    if (m_tdata[FLD_W-1] === 1'b1) overflow_seen++;
    if (token_q.size() == 0) begin
      $error("result transaction with nothing expected: event %0d, tdata 0x%0h",
             m_tuser, m_tdata);
      mismatches++;
    end else begin
      e = token_q.pop_front();
      check_field("event_res", 32'(e.ev), 32'(m_tuser));
      check_field("token_start", 32'(e.start), 32'(m_tdata[START_W-1:0]));
      check_field("token_length", 32'(e.len), 32'(m_tdata[START_W +: LEN_W]));
      check_field("arg_index", 32'(e.arg), 32'(m_tdata[START_W+LEN_W +: ARG_W]));
      check_field("stage_index", 32'(e.stg),
                  32'(m_tdata[START_W+LEN_W+ARG_W +: STG_W]));
      check_field("overflow", 32'(e.ovf), 32'(m_tdata[FLD_W-1]));
      check_field("last", 32'(e.last), 32'(m_tlast));
      check_field("tdata zero fill", 32'd0, 32'(m_tdata >> FLD_W));
    end
  endtask

  // Monitor both channels
  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      token_q.delete();
      mismatches    = 0;
      results_seen  = 0;
      overflow_seen = 0;
    end else begin
      if ($isunknown({s_tready, m_tvalid})) begin
        $error("handshake output unknown: s_tready %b, m_tvalid %b", s_tready, m_tvalid);
        mismatches++;
      end
      if (s_tvalid && s_tready) tokenize(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
    outstanding <= token_q.size();
  end

endmodule

// File: dv/tb_command_line_pipe_tokenizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_line_pipe_tokenizer_core
// Self-checking bench for the command line pipe tokenizer.
// ----------------------------------------------------------------------------
// Feeds command lines byte by byte with an end-of-line transaction after
// each. A short directed set covers blank codes, quotes, pipes, byte 0 and
// 255, empty and unterminated quotes. Random lines follow, mostly built from
// words, quoted words and pipes, with some raw noise, plus lines that run
// the word count and the stage count into saturation.
// Both sides stall at random; a checker module predicts and compares.

module tb_command_line_pipe_tokenizer_core;
  import clpt_pkg::*;

  localparam int FLD_W = $clog2(LINE_MAX_LEN_DEF) + $clog2(LINE_MAX_LEN_DEF + 1) +
                         $clog2(MAX_ARGS_DEF + 1) + $clog2(MAX_STAGES_DEF) + 1;
  localparam int TDATA_W      = ((FLD_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1450;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic [7:0]         s_tdata  = 8'd0;
  logic               s_tuser  = KIND_CHAR;
  logic               m_tready = 1'b0;
  logic               s_tready;
  logic               m_tvalid;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;

  int mismatches;
  int outstanding;
  int results_seen;
  int overflow_seen;

  bit         steady = 1'b0;  // no idling on either side while set
  int         cycles = 0;
  int         items_sent = 0;
  int         lines_sent = 0;
  int         random_items = 0;
  logic [7:0] line_q[$];

  command_line_pipe_tokenizer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  token_stream_checker #(.TDATA_W(TDATA_W)) u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .overflow_seen (overflow_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver stalls at random, about 28 percent of the time, unless steady is set
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 28);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One input transaction, after a random idle gap
  task automatic send_item(logic kind, logic [7:0] c);
    int gap = 0;
    if (!steady) while ($urandom_range(99) < 28) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Queued line bytes, then end of line (its byte is don't-care)
  task automatic send_line();
    foreach (line_q[i]) send_item(KIND_CHAR, line_q[i]);
    send_item(KIND_EOL, 8'($urandom_range(255)));
    line_q.delete();
    lines_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic bit is_plain(logic [7:0] c);
    return !((c == 8'd32) || (c >= 8'd9 && c <= 8'd13) ||
             c == CH_PIPE || c == CH_SQUOTE || c == CH_DQUOTE);
  endfunction

  function automatic logic [7:0] blank_char();
    int r = $urandom_range(6);
    return (r == 6) ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (!is_plain(c));
    return c;
  endfunction

  function automatic logic [7:0] quoted_char(logic [7:0] q);
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == q);
    return c;
  endfunction

  // Append blanks and one token: word, quoted word, pipe or raw noise
  task automatic add_token(bit allow_noise);
    int         sel;
    int         n;
    logic [7:0] q;
    n = $urandom_range(3);
    if (line_q.size() != 0 && $urandom_range(3) == 0) n = 0;
    repeat (n) line_q.push_back(blank_char());
    sel = $urandom_range(allow_noise ? 9 : 8);
    if (sel <= 3) begin
      line_q.push_back(word_char());
      repeat ($urandom_range(5)) begin
        if ($urandom_range(5) == 0)
          line_q.push_back($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE);
        else
          line_q.push_back(word_char());
      end
    end else if (sel <= 7) begin
      q = (sel <= 5) ? CH_SQUOTE : CH_DQUOTE;
      line_q.push_back(q);
      repeat ($urandom_range(5)) line_q.push_back(quoted_char(q));
      line_q.push_back(q);
    end else if (sel == 8) begin
      line_q.push_back(CH_PIPE);
    end else begin
      repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Ordinary random line, sometimes ending inside an open quote
  task automatic build_line();
    logic [7:0] q;
    repeat ($urandom_range(8)) add_token(1'b1);
    if ($urandom_range(7) == 0) begin
      q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      line_q.push_back(q);
      repeat ($urandom_range(3)) line_q.push_back(quoted_char(q));
    end
    if ($urandom_range(3) == 0) line_q.push_back(blank_char());
  endtask

  // More words than the argument limit, then a new stage
  task automatic build_arg_flood();
    repeat ($urandom_range(MAX_ARGS_DEF + 2, MAX_ARGS_DEF + 8)) begin
      line_q.push_back(word_char());
      line_q.push_back(blank_char());
    end
    line_q.push_back(CH_PIPE);
    line_q.push_back(word_char());
  endtask

  // At least as many pipes as the stage limit
  task automatic build_stage_flood();
    repeat ($urandom_range(MAX_STAGES_DEF, MAX_STAGES_DEF + 4)) begin
      if ($urandom_range(1)) line_q.push_back(word_char());
      line_q.push_back(CH_PIPE);
    end
    line_q.push_back(word_char());
  endtask

  initial begin
    int rline;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte 0 and 255, blank edges, quote in word, pipe in and out
    // of quotes, empty quotes, word open at end of line
    line_q = '{8'h00, 8'h08, 8'h09, 8'h61, CH_SQUOTE, 8'h62, CH_PIPE, CH_DQUOTE,
               8'h20, CH_PIPE, CH_DQUOTE, 8'h0D, CH_SQUOTE, CH_SQUOTE, 8'hFF};
    send_line();
    // Empty line
    send_line();
    // Non-blank neighbor of the blank range, unterminated double quote
    line_q = '{8'h0E, 8'h20, CH_DQUOTE, 8'h78};
    send_line();
    // Pipe with no words, then unterminated empty single quote
    line_q = '{CH_PIPE, CH_SQUOTE};
    send_line();
    drain();

    // Random lines, with saturating lines in between
    rline = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (rline)
        6:  build_arg_flood();
        12: build_stage_flood();
        default: build_line();
      endcase
      steady = (random_items >= 500 && random_items < 800);
      random_items += line_q.size() + 1;
      send_line();
      if (rline % 40 == 39) drain();
      rline++;
    end
    steady = 1'b0;

    // Let every result come back, then watch for stray ones
    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d lines in %0d input transactions, saturating lines included;",
             lines_sent, items_sent);
    $display("%0d result transactions checked, %0d of them with overflow set.",
             results_seen, overflow_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
